@@ hdl/slps_pkg.sv @@
`default_nettype none
package slps_pkg;
   localparam int LedCount = 4;
   localparam logic [7:0]  PwmResReset    = 8'd20;
   localparam logic [15:0] ErrDispReset   = 16'd3000;
   localparam logic [15:0] BlinkOnReset   = 16'd60;
   localparam logic [15:0] BlinkCycReset  = 16'd200;
   localparam logic [15:0] PauseReset     = 16'd1000;
   localparam logic [2:0]  RegPwmRes  = 3'd0;
   localparam logic [2:0]  RegErrDisp = 3'd1;
   localparam logic [2:0]  RegBlinkOn = 3'd2;
   localparam logic [2:0]  RegBlinkCyc = 3'd3;
   localparam logic [2:0]  RegPause   = 3'd4;
   localparam logic [3:0] MaskBlue   = 4'b0010;
   localparam logic [3:0] MaskRed    = 4'b0100;
   localparam logic [3:0] MaskGreen  = 4'b1000;
   localparam logic [3:0] MaskWhite  = 4'b1110;
   localparam logic [3:0] MaskYellow = 4'b1100;
   localparam logic [3:0] MaskPurple = 4'b0110;
   localparam logic [8:0] Period300 = 9'd300;
   localparam logic [8:0] Period500 = 9'd500;
   // ceil(2^29/75) and ceil(2^29/125): x*256/300 = (x*64)/75, x*256/500 = (x*64)/125,
   // exact for x*64 < 2^22
   localparam logic [22:0] Recip75  = 23'd7158279;
   localparam logic [22:0] Recip125 = 23'd4294968;

   // controller -> datapath
   typedef struct packed {
      logic start_div;   // load divider
      logic pwm_tick;    // emit mask, advance counters
      logic status_upd;  // apply status pattern
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_sts_type;
endpackage
`default_nettype wire

@@ hdl/slps_ctrl.sv @@
`default_nettype none
module slps_ctrl
   import slps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic       in_func,
   output logic            in_ready,
   output logic            out_valid,
   input  wire logic       out_ready,
   output dp_cmd_type      cmd,
   input  dp_sts_type      sts
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StOut  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic take;

   assign in_ready  = (state_ff == StIdle);
   assign out_valid = (state_ff == StOut);
   assign take = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         StIdle: begin
            if (take) begin
               if (in_func) begin
                  cmd.start_div = 1'b1;
                  state_in = StDiv;
               end else begin
                  cmd.pwm_tick = 1'b1;
                  state_in = StOut;
               end
            end
         end
         StDiv: begin
            if (sts.div_done) begin
               cmd.status_upd = 1'b1;
               state_in = StOut;
            end
         end
         StOut: begin
            if (out_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ hdl/slps_dp.sv @@
`default_nettype none
module slps_dp
   import slps_pkg::*;
#(
   parameter int LED_COUNT = LedCount
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  dp_cmd_type       cmd,
   output dp_sts_type       sts,
   input  wire logic [7:0]  in_dt_ms,
   input  wire logic [4:0]  in_alarm,
   input  wire logic [2:0]  in_faults,
   input  wire logic [7:0]  in_mag,
   input  wire logic [3:0]  in_mode,
   input  wire logic        in_armed,
   input  wire logic [2:0]  in_periph,
   input  wire logic [7:0]  pwm_res,
   input  wire logic [15:0] err_disp,
   input  wire logic [15:0] blink_on,
   input  wire logic [15:0] blink_cyc,
   input  wire logic [15:0] pause_len,
   output logic [LED_COUNT-1:0] led_on
);
   // captured item
   logic [7:0] dt_ff;
   logic [4:0] alarm_ff;
   logic [2:0] faults_ff, periph_ff;
   logic [7:0] mag_ff;
   logic [3:0] mode_ff;
   logic armed_ff;

   // state
   logic [15:0] bright_ff [LED_COUNT];
   logic [LED_COUNT-1:0] dir_ff;
   logic [7:0]  cnt_ff [LED_COUNT];
   logic [15:0] ptimer_ff, ftimer_ff;
   logic err_ff;
   logic [7:0] bcount_ff;
   logic [1:0] rphase_ff;
   logic [7:0] rstep_ff;
   logic [LED_COUNT-1:0] mask_ff;

   // breath step res*dt*256/period by reciprocal multiply:
   // first registers res*dt, then registers the quotient
   logic [15:0] prod_ff;
   logic        sel500_ff;
   logic [15:0] quo_ff;
   logic        dcnt_ff;
   logic        dbusy_ff;
   logic [44:0] recip_w;

   assign recip_w = {7'd0, prod_ff, 6'd0} * {22'd0, (sel500_ff ? Recip125 : Recip75)};
   assign sts.div_done = dbusy_ff && !dcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff <= 1'b0;
      end else if (cmd.start_div) begin
         dbusy_ff <= 1'b1;
         dcnt_ff <= 1'b1;
      end else if (dbusy_ff) begin
         if (!dcnt_ff) dbusy_ff <= 1'b0;
         else dcnt_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         prod_ff <= pwm_res * in_dt_ms;
         sel500_ff <= in_alarm[3] && in_mag == 8'd0;
         dt_ff <= in_dt_ms;
         alarm_ff <= in_alarm;
         faults_ff <= in_faults;
         mag_ff <= in_mag;
         mode_ff <= in_mode;
         armed_ff <= in_armed;
         periph_ff <= in_periph;
      end else if (dbusy_ff && dcnt_ff) begin
         quo_ff <= recip_w[44:29];
      end
   end

   // status-tick next state
   logic [15:0] full_w;
   logic [16:0] step_w;
   logic [15:0] bright_in [LED_COUNT];
   logic [LED_COUNT-1:0] dir_in;
   logic [15:0] ptimer_in, ftimer_in;
   logic err_in;
   logic [7:0] bcount_in, rstep_in;
   logic [1:0] rphase_in;

   assign full_w = {pwm_res, 8'd0};
   assign step_w = {1'b0, quo_ff};

   // helpers
   function automatic logic [16:0] add_t(input logic [15:0] t, input logic [7:0] d);
      return {1'b0, t} + {9'd0, d};
   endfunction

   logic [15:0] pt_add;
   logic [16:0] ft_add;
   logic        cb_on, cb_done, tr_pause, tr_err;
   logic        fl40_on, fl40_wrap, fl60_on, fl60_wrap;
   logic [3:0]  blink_mask, bright_mask;
   logic [1:0]  rs_idx;
   logic [3:0]  pcolor;

   always_comb begin
      pt_add = ptimer_ff + {8'd0, dt_ff};
      ft_add = add_t(ftimer_ff, dt_ff);
      cb_on = ptimer_ff < blink_on;
      cb_done = pt_add > blink_cyc;
      tr_pause = pt_add > pause_len;
      tr_err = pt_add > err_disp;
      fl40_on = ftimer_ff < 16'd40;
      fl40_wrap = ft_add >= 17'd80;
      fl60_on = ftimer_ff < 16'd60;
      fl60_wrap = ft_add >= 17'd120;
      rs_idx = rstep_ff[1:0];
      unique case (rs_idx)
         2'd0: pcolor = MaskBlue;
         2'd1: pcolor = MaskYellow;
         default: pcolor = MaskPurple;
      endcase
   end

   always_comb begin
      logic err_now;
      logic [7:0] nblinks;
      logic do_set, do_breath;
      logic [3:0] smask;
      logic [17:0] up;
      logic cb_go;
      err_now = err_ff | alarm_ff[0];
      err_in = err_now;
      ptimer_in = ptimer_ff;
      ftimer_in = ftimer_ff;
      bcount_in = bcount_ff;
      rphase_in = rphase_ff;
      rstep_in = rstep_ff;
      dir_in = dir_ff;
      for (int i = 0; i < LED_COUNT; i++) bright_in[i] = bright_ff[i];
      do_set = 1'b0;
      do_breath = 1'b0;
      smask = '0;
      bright_mask = '0;
      nblinks = faults_ff[0] ? 8'd2 : (faults_ff[1] ? 8'd3 : 8'd4);
      up = '0;
      cb_go = 1'b0;
      blink_mask = '0;
      if (err_now) begin
         do_set = 1'b1; smask = MaskRed;
         if (tr_err) begin ptimer_in = '0; err_in = 1'b0; end
         else ptimer_in = pt_add;
      end else if (faults_ff != 3'd0) begin
         if (bcount_ff < nblinks) begin
            cb_go = 1'b1; blink_mask = MaskBlue;
            if (cb_done) bcount_in = bcount_ff + 8'd1;
         end else begin
            if (tr_pause) begin ptimer_in = '0; bcount_in = '0; end
            else ptimer_in = pt_add;
         end
      end else if (alarm_ff[1]) begin
         bright_in[3] = full_w; bright_in[2] = '0; bright_in[1] = '0;
      end else if (alarm_ff[2] || mag_ff == 8'd2 || mag_ff == 8'd100) begin
         do_set = 1'b1;
         smask = fl40_on ? ((mag_ff == 8'd100 && !alarm_ff[2]) ? MaskGreen : MaskBlue) : 4'd0;
         ftimer_in = fl40_wrap ? 16'd0 : ft_add[15:0];
      end else if (mag_ff != 8'd0) begin
         do_breath = 1'b1; bright_mask = (mag_ff == 8'd1) ? MaskGreen : MaskBlue;
      end else if (alarm_ff[3]) begin
         do_breath = 1'b1; bright_mask = MaskRed;
      end else if (alarm_ff[4]) begin
         do_set = 1'b1; smask = fl60_on ? MaskRed : 4'd0;
         ftimer_in = fl60_wrap ? 16'd0 : ft_add[15:0];
      end else begin
         if (rphase_ff == 2'd0) begin
            if (rstep_ff <= {4'd0, mode_ff}) begin
               cb_go = 1'b1; blink_mask = armed_ff ? MaskGreen : MaskWhite;
               if (cb_done) rstep_in = rstep_ff + 8'd1;
            end else begin
               rstep_in = '0; rphase_in = 2'd1;
            end
         end else if (rphase_ff == 2'd1) begin
            if (rstep_ff < 8'd3) begin
               if (periph_ff[rs_idx]) begin
                  cb_go = 1'b1; blink_mask = pcolor;
                  if (cb_done) rstep_in = rstep_ff + 8'd1;
               end else rstep_in = rstep_ff + 8'd1;
            end
            if (rstep_in >= 8'd3) begin rphase_in = 2'd2; rstep_in = '0; end
         end else begin
            do_set = 1'b1; smask = '0;
            if (tr_pause) begin ptimer_in = '0; rphase_in = 2'd0; rstep_in = '0; end
            else ptimer_in = pt_add;
         end
      end
      if (cb_go) begin
         do_set = 1'b1; smask = cb_on ? blink_mask : 4'd0;
         ptimer_in = cb_done ? 16'd0 : pt_add;
      end
      if (do_set)
         for (int i = 0; i < LED_COUNT; i++) bright_in[i] = smask[i] ? full_w : 16'd0;
      if (do_breath)
         for (int i = 0; i < LED_COUNT; i++) begin
            if (!bright_mask[i]) bright_in[i] = '0;
            else if (!dir_ff[i]) begin
               up = {2'b0, bright_ff[i]} + {1'b0, step_w};
               if (up > 18'hFFFF) up = 18'hFFFF;
               bright_in[i] = up[15:0];
               if (up > {2'b0, full_w}) dir_in[i] = 1'b1;
            end else if (step_w > {1'b0, bright_ff[i]}) begin
               bright_in[i] = '0; dir_in[i] = 1'b0;
            end else bright_in[i] = bright_ff[i] - step_w[15:0];
         end
   end

   // mask from counters and (new) brightness
   logic [LED_COUNT-1:0] pwm_mask, upd_mask;
   always_comb begin
      for (int i = 0; i < LED_COUNT; i++) begin
         pwm_mask[i] = {cnt_ff[i], 8'd0} < bright_ff[i];
         upd_mask[i] = {cnt_ff[i], 8'd0} < bright_in[i];
      end
   end
   assign led_on = mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            bright_ff[i] <= (i == 1) ? {PwmResReset, 8'd0} : 16'd0;
            cnt_ff[i] <= '0;
         end
         dir_ff <= '0;
         ptimer_ff <= '0; ftimer_ff <= '0; err_ff <= 1'b0;
         bcount_ff <= '0; rphase_ff <= '0; rstep_ff <= '0;
         mask_ff <= '0;
      end else if (cmd.pwm_tick) begin
         mask_ff <= pwm_mask;
         for (int i = 0; i < LED_COUNT; i++)
            cnt_ff[i] <= ({1'b0, cnt_ff[i]} + 9'd1 >= {1'b0, pwm_res}) ? 8'd0
                         : cnt_ff[i] + 8'd1;
      end else if (cmd.status_upd) begin
         mask_ff <= upd_mask;
         for (int i = 0; i < LED_COUNT; i++) bright_ff[i] <= bright_in[i];
         dir_ff <= dir_in;
         ptimer_ff <= ptimer_in; ftimer_ff <= ftimer_in; err_ff <= err_in;
         bcount_ff <= bcount_in; rphase_ff <= rphase_in; rstep_ff <= rstep_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/status_led_pattern_sequencer_core.sv @@
`default_nettype none
// Status LED pattern sequencer for four LEDs (aux, blue, red, green). A pwm
// tick (func 0) returns the on mask from the per-LED counters and advances
// them; the result is offered the cycle after the transfer in. A status tick
// (func 1) registers resolution*dt, then gets the breath step by one
// reciprocal multiply, then applies the highest-priority pattern; the result
// is offered once the product, the quotient and the pattern are registered.
// One item is in flight at a time; the result register holds until taken and
// the input waits meanwhile. Registers at 4*i via the csr_ port:
// pwm_resolution, error_display_ms, blink_on_ms, blink_cycle_ms, pause_ms.
module status_led_pattern_sequencer_core
   import slps_pkg::*;
#(
   parameter int LED_COUNT = LedCount
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: dt_ms[7:0], alarm_flags[12:8], sensor_faults[15:13],
   // mag_cal_phase[23:16], nav_mode[27:24], armed[28], peripheral_flags[31:29]
   input  wire logic [31:0] req_tdata,
   // tuser: func
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: led_on[3:0]
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [7:0]  pwm_res_ff;
   logic [15:0] err_disp_ff, blink_on_ff, blink_cyc_ff, pause_ff;
   logic [2:0]  reg_idx;
   logic        wr;
   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [LED_COUNT-1:0] led_on;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_res_ff <= PwmResReset;
         err_disp_ff <= ErrDispReset;
         blink_on_ff <= BlinkOnReset;
         blink_cyc_ff <= BlinkCycReset;
         pause_ff <= PauseReset;
      end else if (wr) begin
         unique case (reg_idx)
            RegPwmRes:   pwm_res_ff <= csr_pwdata[7:0];
            RegErrDisp:  err_disp_ff <= csr_pwdata[15:0];
            RegBlinkOn:  blink_on_ff <= csr_pwdata[15:0];
            RegBlinkCyc: blink_cyc_ff <= csr_pwdata[15:0];
            RegPause:    pause_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         RegPwmRes:   csr_prdata = {24'd0, pwm_res_ff};
         RegErrDisp:  csr_prdata = {16'd0, err_disp_ff};
         RegBlinkOn:  csr_prdata = {16'd0, blink_on_ff};
         RegBlinkCyc: csr_prdata = {16'd0, blink_cyc_ff};
         RegPause:    csr_prdata = {16'd0, pause_ff};
         default:     csr_prdata = '0;
      endcase
   end

   slps_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_func(req_tuser), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd, .sts
   );

   slps_dp #(.LED_COUNT(LED_COUNT)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_dt_ms(req_tdata[7:0]), .in_alarm(req_tdata[12:8]),
      .in_faults(req_tdata[15:13]), .in_mag(req_tdata[23:16]),
      .in_mode(req_tdata[27:24]), .in_armed(req_tdata[28]),
      .in_periph(req_tdata[31:29]),
      .pwm_res(pwm_res_ff), .err_disp(err_disp_ff), .blink_on(blink_on_ff),
      .blink_cyc(blink_cyc_ff), .pause_len(pause_ff),
      .led_on
   );

   assign rsp_tdata = {{(8-LED_COUNT){1'b0}}, led_on};

`ifndef SYNTH
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pwm_tick && cmd.status_upd)) else $error("pwm and status together");
   a_pwm_out: assert property (@(posedge clock) disable iff (reset)
      cmd.pwm_tick |=> rsp_tvalid) else $error("pwm result missing");
`endif
endmodule
`default_nettype wire
